>>> src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue and the testbench; depends on nothing.
package spq_pkg;

    // Fixed widths of the transaction fields
    localparam int ID_FIELD_W    = 16;
    localparam int PRI_FIELD_W   = 8;
    localparam int COUNT_FIELD_W = 5;
    localparam int STATUS_W      = 2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_EMPTY_POP  = 2'd1,
        STATUS_FULL_DROP  = 2'd2
    } status_t;

    // Request mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_op_t;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted queue: holds an (id, priority) entry and a valid bit.
// Depends on spq_pkg; chained by sorted_priority_queue.
module spq_cell #(
    parameter int ID_WIDTH       = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spq_pkg::cell_op_t         op,
    input  logic [ID_WIDTH-1:0]       new_id,
    input  logic [PRIORITY_WIDTH-1:0] new_pri,
    // neighbor toward the head
    input  logic                      left_before,
    input  logic [ID_WIDTH-1:0]       left_id,
    input  logic [PRIORITY_WIDTH-1:0] left_pri,
    input  logic                      left_valid,
    // neighbor toward the tail
    input  logic [ID_WIDTH-1:0]       right_id,
    input  logic [PRIORITY_WIDTH-1:0] right_pri,
    input  logic                      right_valid,
    // this slot
    output logic                      ahead,
    output logic [ID_WIDTH-1:0]       id,
    output logic [PRIORITY_WIDTH-1:0] pri,
    output logic                      valid
);

    logic [ID_WIDTH-1:0]       id_reg, id_next;
    logic [PRIORITY_WIDTH-1:0] pri_reg, pri_next;
    logic                      valid_reg, valid_next;

    // New entry belongs at or ahead of this slot (empty slots always qualify)
    assign ahead = !valid_reg
                || (new_pri > pri_reg)
                || ((new_pri == pri_reg) && (new_id <= id_reg));

    // Insert: shift right from the insertion point; remove: shift left
    always_comb
    begin
        id_next    = id_reg;
        pri_next   = pri_reg;
        valid_next = valid_reg;
        if (op.insert)
        begin
            if (left_before)
            begin
                id_next    = left_id;
                pri_next   = left_pri;
                valid_next = left_valid;
            end
            else if (ahead)
            begin
                id_next    = new_id;
                pri_next   = new_pri;
                valid_next = 1'b1;
            end
        end
        else if (op.remove)
        begin
            id_next    = right_id;
            pri_next   = right_pri;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg    <= '0;
            pri_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            id_reg    <= id_next;
            pri_reg   <= pri_next;
            valid_reg <= valid_next;
        end
    end

    assign id    = id_reg;
    assign pri   = pri_reg;
    assign valid = valid_reg;

endmodule

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus count and result.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue kept sorted in a row of CAPACITY cells; cell 0 is
// the head (highest priority, lowest id among equal priorities). Each input
// transaction inserts (mode 0) or removes the head (mode 1) and yields exactly
// one result transaction reporting the head id, emptiness, count and status.
// Every cell compares the incoming entry with its own in parallel and shifts
// with its neighbor in the same cycle, so one transaction completes per clock
// cycle unless out_ready stalls; a new transaction enters in the cycle its
// predecessor's result is taken: one per cycle sustained while out_ready is
// high. An empty remove or a full insert leaves the contents unchanged and
// reports a status code. No clearing pass is needed after reset.
module sorted_priority_queue #(
    parameter int CAPACITY       = 16,
    parameter int ID_WIDTH       = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [spq_pkg::ID_FIELD_W-1:0]   item_id,
    input  logic [spq_pkg::PRI_FIELD_W-1:0]  priority_req,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [spq_pkg::ID_FIELD_W-1:0]   head_id,
    output logic                             queue_empty,
    output logic [spq_pkg::COUNT_FIELD_W-1:0] entry_count,
    output logic [spq_pkg::STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      accept;
    logic [ID_WIDTH-1:0]       new_id;
    logic [PRIORITY_WIDTH-1:0] new_pri;
    spq_pkg::cell_op_t         op;
    spq_pkg::status_t          status_reg, status_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      is_full, is_empty;

    logic [CAPACITY-1:0]       cell_before;
    logic [CAPACITY-1:0]       cell_valid;
    logic [ID_WIDTH-1:0]       cell_id  [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] cell_pri [CAPACITY];

    // Handshake: result register drains as the next transaction enters
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Fit input fields to the stored widths
    genvar b;
    generate
        for (b = 0; b < ID_WIDTH; b++)
        begin : g_id_in
            if (b < spq_pkg::ID_FIELD_W)
            begin : g_bit
                assign new_id[b] = item_id[b];
            end
            else
            begin : g_zero
                assign new_id[b] = 1'b0;
            end
        end
        for (b = 0; b < PRIORITY_WIDTH; b++)
        begin : g_pri_in
            if (b < spq_pkg::PRI_FIELD_W)
            begin : g_bit
                assign new_pri[b] = priority_req[b];
            end
            else
            begin : g_zero
                assign new_pri[b] = 1'b0;
            end
        end
    endgenerate

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Decode the transaction into a cell operation, count and status
    always_comb
    begin
        op.insert      = 1'b0;
        op.remove      = 1'b0;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = spq_pkg::STATUS_DONE;
            if (mode == spq_pkg::MODE_INSERT)
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::STATUS_FULL_DROP;
                end
                else
                begin
                    op.insert  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = spq_pkg::STATUS_EMPTY_POP;
                end
                else
                begin
                    op.remove  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= spq_pkg::STATUS_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Chain of cells; the ends see an empty neighbor
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      l_before;
            logic [ID_WIDTH-1:0]       l_id;
            logic [PRIORITY_WIDTH-1:0] l_pri;
            logic                      l_valid;
            logic [ID_WIDTH-1:0]       r_id;
            logic [PRIORITY_WIDTH-1:0] r_pri;
            logic                      r_valid;

            if (i == 0)
            begin : g_head
                assign l_before = 1'b0;
                assign l_id     = '0;
                assign l_pri    = '0;
                assign l_valid  = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_before = cell_before[i-1];
                assign l_id     = cell_id[i-1];
                assign l_pri    = cell_pri[i-1];
                assign l_valid  = cell_valid[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_id    = '0;
                assign r_pri   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_id    = cell_id[i+1];
                assign r_pri   = cell_pri[i+1];
                assign r_valid = cell_valid[i+1];
            end

            spq_cell #(
                .ID_WIDTH       (ID_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .new_id      (new_id),
                .new_pri     (new_pri),
                .left_before (l_before),
                .left_id     (l_id),
                .left_pri    (l_pri),
                .left_valid  (l_valid),
                .right_id    (r_id),
                .right_pri   (r_pri),
                .right_valid (r_valid),
                .ahead       (cell_before[i]),
                .id          (cell_id[i]),
                .pri         (cell_pri[i]),
                .valid       (cell_valid[i])
            );
        end
    endgenerate

    // Result fields read straight from the updated state
    generate
        for (b = 0; b < spq_pkg::ID_FIELD_W; b++)
        begin : g_head_out
            if (b < ID_WIDTH)
            begin : g_bit
                assign head_id[b] = cell_valid[0] & cell_id[0][b];
            end
            else
            begin : g_zero
                assign head_id[b] = 1'b0;
            end
        end
        for (b = 0; b < spq_pkg::COUNT_FIELD_W; b++)
        begin : g_cnt_out
            if (b < CNT_W)
            begin : g_bit
                assign entry_count[b] = count_reg[b];
            end
            else
            begin : g_zero
                assign entry_count[b] = 1'b0;
            end
        end
    endgenerate

    assign queue_empty = is_empty;
    assign status      = status_reg;
    assign out_valid   = out_valid_reg;

endmodule

>>> verif/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: directed and random insert/remove traffic.
// Depends on spq_pkg and the sorted_priority_queue RTL; a scoreboard class predicts each result.
module sorted_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 430;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int ID_W         = spq_pkg::ID_FIELD_W;
    localparam int PRI_W        = spq_pkg::PRI_FIELD_W;
    localparam int CNT_W        = spq_pkg::COUNT_FIELD_W;
    localparam int ST_W         = spq_pkg::STATUS_W;

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic [ID_W-1:0]  head;
        logic             empty;
        logic [CNT_W-1:0] count;
        spq_pkg::status_t st;
    } queue_view_t;

    // Shadow copy of the sorted queue plus the list of pending result reports
    class queue_scoreboard;
        logic [ID_W-1:0]  slot_id  [QUEUE_DEPTH];
        logic [PRI_W-1:0] slot_pri [QUEUE_DEPTH];
        int unsigned      held;
        queue_view_t      pending_views[$];
        int               errors;
        int               n_sent;
        int               n_insert;
        int               n_remove;
        int               n_drop;
        int               n_empty_pop;
        int unsigned      peak;

        function new();
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_id[i]  = '0;
                slot_pri[i] = '0;
            end
            held        = 0;
            errors      = 0;
            n_sent      = 0;
            n_insert    = 0;
            n_remove    = 0;
            n_drop      = 0;
            n_empty_pop = 0;
            peak        = 0;
        endfunction

        // Apply one accepted request to the shadow queue and queue its result
        function void note_request(logic m, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
            queue_view_t view;
            int unsigned pos;
            bit          found;
            view.st = spq_pkg::STATUS_DONE;
            n_sent++;
            if (m == spq_pkg::MODE_INSERT)
            begin
                n_insert++;
                if (held >= QUEUE_DEPTH)
                begin
                    view.st = spq_pkg::STATUS_FULL_DROP;
                    n_drop++;
                end
                else
                begin
                    // first slot the new entry outranks; ties on priority go by lower id
                    pos   = held;
                    found = 1'b0;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (!found && i < held &&
                            (pri > slot_pri[i] || (pri == slot_pri[i] && id <= slot_id[i])))
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = QUEUE_DEPTH - 1; i > 0; i--)
                    begin
                        if (i <= held && i > pos)
                        begin
                            slot_id[i]  = slot_id[i-1];
                            slot_pri[i] = slot_pri[i-1];
                        end
                    end
                    slot_id[pos]  = id;
                    slot_pri[pos] = pri;
                    held++;
                    if (held > peak)
                        peak = held;
                end
            end
            else
            begin
                n_remove++;
                if (held == 0)
                begin
                    view.st = spq_pkg::STATUS_EMPTY_POP;
                    n_empty_pop++;
                end
                else
                begin
                    // shift everything one slot toward the head
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (i + 1 < held)
                        begin
                            slot_id[i]  = slot_id[i+1];
                            slot_pri[i] = slot_pri[i+1];
                        end
                    end
                    held--;
                    slot_id[held]  = '0;
                    slot_pri[held] = '0;
                end
            end
            view.head  = (held > 0) ? slot_id[0] : '0;
            view.empty = (held == 0);
            view.count = CNT_W'(held);
            pending_views.push_back(view);
        endfunction

        // Print one mismatch line and count it
        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Compare one observed result with the oldest pending prediction
        task check_result(queue_view_t got);
            queue_view_t want;
            if (pending_views.size() == 0)
            begin
                report("result transaction with none pending");
            end
            else
            begin
                want = pending_views.pop_front();
                if (got.head !== want.head)
                    report($sformatf("head_id got %0d expected %0d", got.head, want.head));
                if (got.empty !== want.empty)
                    report($sformatf("queue_empty got %0d expected %0d",
                                     got.empty, want.empty));
                if (got.count !== want.count)
                    report($sformatf("entry_count got %0d expected %0d",
                                     got.count, want.count));
                if (got.st !== want.st)
                    report($sformatf("status code got %0d expected %0d", got.st, want.st));
            end
        endtask

        function int pending();
            return pending_views.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             mode;
    logic [ID_W-1:0]  item_id;
    logic [PRI_W-1:0] priority_req;
    logic             out_valid;
    logic             out_ready;
    logic [ID_W-1:0]  head_id;
    logic             queue_empty;
    logic [CNT_W-1:0] entry_count;
    logic [ST_W-1:0]  status;

    queue_scoreboard sb = new();
    bit              steady;

    sorted_priority_queue #(
        .CAPACITY       (QUEUE_DEPTH),
        .ID_WIDTH       (ID_W),
        .PRIORITY_WIDTH (PRI_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .item_id      (item_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head_id      (head_id),
        .queue_empty  (queue_empty),
        .entry_count  (entry_count),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one request and hold it until the queue takes it
    task automatic send_req(input logic m, input logic [ID_W-1:0] id,
                            input logic [PRI_W-1:0] pri);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        item_id      <= id;
        priority_req <= pri;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(m, id, pri);
    endtask

    // Random request; ids and priorities lean toward ties and extremes
    task automatic send_random(input int insert_pct);
        logic             m;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        m = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_REMOVE;
        case ($urandom_range(0, 3))
            0:       id = ID_W'($urandom_range(0, 3));
            1:       id = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: id = ID_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       pri = PRI_W'($urandom_range(0, 3));
            1:       pri = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: pri = PRI_W'($urandom);
        endcase
        send_req(m, id, pri);
    endtask

    // Result side: random back-pressure, one transaction per ready window
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Capture each result at the edge, compare once the same-step request is noted
    initial
    begin : result_monitor
        queue_view_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{head_id, queue_empty, entry_count, spq_pkg::status_t'(status)};
                #1;
                sb.check_result(got);
            end
        end
    end

    // Main stimulus
    initial
    begin : stimulus
        int sent_random;
        int phase_len;
        int insert_pct;
        int waited;
        bit paused;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = spq_pkg::MODE_INSERT;
        item_id      = '0;
        priority_req = '0;
        steady       = 1'b0;
        sent_random  = 0;
        paused       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: remove on empty, extreme fields, equal entries, drain past empty
        send_req(spq_pkg::MODE_REMOVE, 16'h0000, 8'h00);
        send_req(spq_pkg::MODE_INSERT, 16'h0000, 8'h00);
        send_req(spq_pkg::MODE_INSERT, 16'hFFFF, 8'hFF);
        send_req(spq_pkg::MODE_INSERT, 16'h0005, 8'hFF);
        send_req(spq_pkg::MODE_INSERT, 16'h0005, 8'hFF);
        send_req(spq_pkg::MODE_INSERT, 16'hFFFF, 8'h00);
        send_req(spq_pkg::MODE_INSERT, 16'h0000, 8'h00);
        send_req(spq_pkg::MODE_INSERT, 16'h1234, 8'h80);
        send_req(spq_pkg::MODE_INSERT, 16'h1233, 8'h80);
        repeat (9)
            send_req(spq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF);
        send_req(spq_pkg::MODE_REMOVE, 16'hA5A5, 8'h5A);

        // random phases: insert-heavy, balanced and remove-heavy runs
        while (sent_random < RANDOM_ITEMS)
        begin
            if (sent_random == 0)
            begin
                phase_len  = 40;
                insert_pct = 90;
            end
            else
            begin
                phase_len = $urandom_range(20, 40);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 90;
                    1:       insert_pct = 50;
                    default: insert_pct = 10;
                endcase
            end
            if (phase_len > RANDOM_ITEMS - sent_random)
                phase_len = RANDOM_ITEMS - sent_random;
            steady = ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                send_random(insert_pct);
                sent_random++;
            end
            // hold off once until every result is back
            if (!paused && sent_random >= RANDOM_ITEMS / 2)
            begin
                paused   = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        steady   = 1'b0;

        // drain, then a few more cycles for anything unexpected
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result transactions never arrived", sb.pending()));

        $display("covered %0d transactions: %0d inserts (%0d dropped full), %0d removes (%0d empty)",
                 sb.n_sent, sb.n_insert, sb.n_drop, sb.n_remove, sb.n_empty_pop);
        $display("deepest queue seen %0d of %0d, %0d mismatches",
                 sb.peak, QUEUE_DEPTH, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
